>>> hw/rtl/vtxs_pkg.sv
// Package for the vertex stride calculator: payload structs, attribute type codes
// and the component and colour size tables. No dependencies.

package vtxs_pkg;

    localparam int unsigned MAX_VERTEX_BYTES = 129;
    localparam int unsigned NUM_TEXCOORDS    = 8;
    localparam int unsigned NUM_MTX_FLAGS    = 9;

    typedef enum logic [1:0] {
        ATTR_NONE    = 2'd0,
        ATTR_DIRECT  = 2'd1,
        ATTR_INDEX8  = 2'd2,
        ATTR_INDEX16 = 2'd3
    } t_attr_type;

    typedef struct packed {
        logic [2:0]  vertex_format;
        logic [16:0] vcd_low;
        logic [15:0] vcd_high;
        logic [31:0] vat_word_a;
        logic [31:0] vat_word_b;
        logic [31:0] vat_word_c;
    } t_query;

    typedef struct packed {
        logic [2:0] format_tag;
        logic [7:0] vertex_bytes;
    } t_result;

    // bytes per component, by format code
    function automatic logic [2:0] comp_size(input logic [2:0] fmt);
        logic [2:0] sz;
        case (fmt)
            3'd0, 3'd1: sz = 3'd1;
            3'd2, 3'd3: sz = 3'd2;
            default:    sz = 3'd4;
        endcase
        return sz;
    endfunction

    // bytes per colour, by format code
    function automatic logic [2:0] color_size(input logic [2:0] fmt);
        logic [2:0] sz;
        case (fmt)
            3'd0, 3'd3: sz = 3'd2;
            3'd1, 3'd4: sz = 3'd3;
            default:    sz = 3'd4;
        endcase
        return sz;
    endfunction

    // stream bytes for one attribute, given its direct size
    function automatic logic [5:0] attr_bytes(input t_attr_type typ, input logic [5:0] direct);
        logic [5:0] sz;
        case (typ)
            ATTR_DIRECT:  sz = direct;
            ATTR_INDEX8:  sz = 6'd1;
            ATTR_INDEX16: sz = 6'd2;
            default:      sz = 6'd0;
        endcase
        return sz;
    endfunction

endpackage

>>> hw/rtl/vtxs_sizer.sv
// Combinational vertex size logic: field extraction and adder tree for one query.
// Depends on vtxs_pkg.

module vtxs_sizer (
    input  vtxs_pkg::t_query  i_query,
    output vtxs_pkg::t_result o_result
);
    import vtxs_pkg::*;

    logic [2:0] tc_fmt [NUM_TEXCOORDS];
    logic       tc_cnt [NUM_TEXCOORDS];
    logic [5:0] tc_bytes [NUM_TEXCOORDS];
    logic [5:0] pos_bytes;
    logic [5:0] nrm_bytes;
    logic [5:0] col0_bytes;
    logic [5:0] col1_bytes;
    logic [3:0] mtx_bytes;
    logic [7:0] tc_sum;
    logic [2:0] pos_comp;
    logic [2:0] nrm_comp;
    logic       nrm_three;

    assign tc_cnt[0] = i_query.vat_word_a[21];
    assign tc_fmt[0] = i_query.vat_word_a[24:22];
    assign tc_cnt[1] = i_query.vat_word_b[0];
    assign tc_fmt[1] = i_query.vat_word_b[3:1];
    assign tc_cnt[2] = i_query.vat_word_b[9];
    assign tc_fmt[2] = i_query.vat_word_b[12:10];
    assign tc_cnt[3] = i_query.vat_word_b[18];
    assign tc_fmt[3] = i_query.vat_word_b[21:19];
    assign tc_cnt[4] = i_query.vat_word_b[27];
    assign tc_fmt[4] = i_query.vat_word_b[30:28];
    assign tc_cnt[5] = i_query.vat_word_c[5];
    assign tc_fmt[5] = i_query.vat_word_c[8:6];
    assign tc_cnt[6] = i_query.vat_word_c[14];
    assign tc_fmt[6] = i_query.vat_word_c[17:15];
    assign tc_cnt[7] = i_query.vat_word_c[23];
    assign tc_fmt[7] = i_query.vat_word_c[26:24];

    always_comb begin
        for (int i = 0; i < NUM_TEXCOORDS; i++) begin
            tc_bytes[i] = attr_bytes(t_attr_type'(i_query.vcd_high[2*i +: 2]),
                                     6'(comp_size(tc_fmt[i])) << tc_cnt[i]);
        end
    end

    always_comb begin
        mtx_bytes = '0;
        for (int i = 0; i < NUM_MTX_FLAGS; i++) begin
            mtx_bytes = mtx_bytes + 4'(i_query.vcd_low[i]);
        end
    end

    assign pos_comp = comp_size(i_query.vat_word_a[3:1]);
    assign pos_bytes = attr_bytes(t_attr_type'(i_query.vcd_low[10:9]),
                                  i_query.vat_word_a[0] ? 6'(pos_comp) * 6'd3
                                                        : 6'(pos_comp) * 6'd2);

    // three-index normals need both the count bit and the option bit
    assign nrm_comp  = comp_size(i_query.vat_word_a[12:10]);
    assign nrm_three = i_query.vat_word_a[9] & i_query.vat_word_a[31];

    always_comb begin
        case (t_attr_type'(i_query.vcd_low[12:11]))
            ATTR_DIRECT:  nrm_bytes = i_query.vat_word_a[9] ? 6'(nrm_comp) * 6'd9
                                                           : 6'(nrm_comp) * 6'd3;
            ATTR_INDEX8:  nrm_bytes = nrm_three ? 6'd3 : 6'd1;
            ATTR_INDEX16: nrm_bytes = nrm_three ? 6'd6 : 6'd2;
            default:      nrm_bytes = 6'd0;
        endcase
    end

    assign col0_bytes = attr_bytes(t_attr_type'(i_query.vcd_low[14:13]),
                                   6'(color_size(i_query.vat_word_a[16:14])));
    assign col1_bytes = attr_bytes(t_attr_type'(i_query.vcd_low[16:15]),
                                   6'(color_size(i_query.vat_word_a[20:18])));

    assign tc_sum = ((8'(tc_bytes[0]) + 8'(tc_bytes[1])) + (8'(tc_bytes[2]) + 8'(tc_bytes[3])))
                  + ((8'(tc_bytes[4]) + 8'(tc_bytes[5])) + (8'(tc_bytes[6]) + 8'(tc_bytes[7])));

    assign o_result.format_tag   = i_query.vertex_format;
    assign o_result.vertex_bytes = ((8'(mtx_bytes) + 8'(pos_bytes)) + (8'(nrm_bytes)
                                   + 8'(col0_bytes))) + (8'(col1_bytes) + tc_sum);

endmodule

>>> hw/rtl/vertex_stride_calculator.sv
// Top level of the vertex stride calculator: query register, sizer, result register.
// Depends on vtxs_pkg and vtxs_sizer.
//
//  channel   direction  valid        stall        payload
//  query     in         i_in_valid   o_in_stall   i_query  (t_query)
//  result    out        o_out_valid  i_out_stall  o_result (t_result)
//
// One query per cycle while o_in_stall is low; a result leaves through the query
// register, then the result register after the sizer logic.
// Reset clears both stage valid flags; payload registers are not reset.
// A stalled result holds in the result register while one more query may
// still enter the query register; input stalls only when both are full.

module vertex_stride_calculator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vtxs_pkg::t_query  i_query,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vtxs_pkg::t_result o_result
);
    import vtxs_pkg::*;

    logic    r_in_valid;
    logic    n_in_valid;
    t_query  r_query;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result sizer_result;
    logic    out_advance;
    logic    in_advance;
    logic    in_xfer;

    assign out_advance = !r_out_valid || !i_out_stall;
    assign in_advance  = !r_in_valid || out_advance;
    assign o_in_stall  = !in_advance;
    assign in_xfer     = i_in_valid && in_advance;

    assign n_in_valid  = in_advance ? i_in_valid : r_in_valid;
    assign n_out_valid = out_advance ? r_in_valid : r_out_valid;

    vtxs_sizer u_sizer (
        .i_query  (r_query),
        .o_result (sizer_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_query <= i_query;
        end
        if (out_advance && r_in_valid) begin
            r_result <= sizer_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_in_valid)
        else $error("accepted query not held in query register");

    a_tag_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_advance) |=>
            (o_out_valid && o_result.format_tag == $past(r_query.vertex_format)))
        else $error("result does not follow its query");

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result.vertex_bytes <= 8'(MAX_VERTEX_BYTES)))
        else $error("vertex size out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("query stalled with free stage");

endmodule
